// ===== rtl/core/sibd_pkg.sv =====
`default_nettype none
package sibd_pkg;

	localparam int NUMBER_W      = 32;
	localparam int NUM_WIDTH_DEF = 32;
	localparam int CHAR_W        = 8;
	localparam int COUNT_W       = 5;
	localparam int ALPHA_W       = 64;
	localparam int SYMBOLS       = 16;
	localparam int SYM_IDX_W     = 4;
	localparam int MAX_BASE      = 16;
	localparam int MIN_BASE      = 2;
	localparam int CFG_INDEX_W   = 2;
	localparam int CFG_DATA_W    = 64;

	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_DIGIT_COUNT   = 2'd0,
		REG_ALPHABET_LOW  = 2'd1,
		REG_ALPHABET_HIGH = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic start;
		logic step;
		logic load_idx;
		logic emit_sign;
		logic emit_digit;
		logic emit_error;
	} dp_cmd_t;

	typedef struct packed {
		logic alpha_ok;
		logic neg;
		logic out_free;
		logic digit_last;
	} dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/sibd_in_if.sv =====
`default_nettype none
interface sibd_in_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [sibd_pkg::NUMBER_W-1:0]  number;

	modport source (output valid, output number, input ready);
	modport sink (input valid, input number, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/sibd_out_if.sv =====
`default_nettype none
interface sibd_out_if;
	logic                          valid;
	logic                          ready;
	logic [sibd_pkg::CHAR_W-1:0]   char_code;
	logic                          last;
	logic                          base_invalid;

	modport source (output valid, output char_code, output last, output base_invalid,
		input ready);
	modport sink (input valid, input char_code, input last, input base_invalid,
		output ready);
endinterface
`default_nettype wire

// ===== rtl/core/sibd_ctrl.sv =====
`default_nettype none
module sibd_ctrl #(
	parameter int NUM_WIDTH = sibd_pkg::NUM_WIDTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire sibd_pkg::dp_status_t status,
	output sibd_pkg::dp_cmd_t         cmd
);

	localparam int CNT_W = $clog2(NUM_WIDTH);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_PREP,
		ST_SIGN,
		ST_DIGIT,
		ST_ERR
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		cmd      = '0;
		case (state_q)
			ST_IDLE:  cmd.start      = in_valid;
			ST_CONV:  cmd.step       = 1'b1;
			ST_PREP:  cmd.load_idx   = 1'b1;
			ST_SIGN:  cmd.emit_sign  = status.out_free;
			ST_DIGIT: cmd.emit_digit = status.out_free;
			ST_ERR:   cmd.emit_error = status.out_free;
			default:  cmd            = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (status.alpha_ok) begin
							state_q <= ST_CONV;
							cnt_q   <= CNT_W'(NUM_WIDTH - 1);
						end else begin
							state_q <= ST_ERR;
						end
					end
				end
				ST_CONV: begin
					if (cnt_q == '0) begin
						state_q <= ST_PREP;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				ST_PREP: begin
					state_q <= status.neg ? ST_SIGN : ST_DIGIT;
				end
				ST_SIGN: begin
					if (status.out_free) begin
						state_q <= ST_DIGIT;
					end
				end
				ST_DIGIT: begin
					if (status.out_free && status.digit_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_ERR: begin
					if (status.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/sibd_dp.sv =====
`default_nettype none
module sibd_dp #(
	parameter int NUM_WIDTH = sibd_pkg::NUM_WIDTH_DEF
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    cfg_wr_en,
	input  wire logic [sibd_pkg::CFG_INDEX_W-1:0]        cfg_index,
	input  wire logic [sibd_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  wire logic signed [sibd_pkg::NUMBER_W-1:0]    number,
	input  wire sibd_pkg::dp_cmd_t                       cmd,
	output sibd_pkg::dp_status_t                         status,
	input  wire logic                                    out_ready,
	output logic                                         out_valid,
	output logic [sibd_pkg::CHAR_W-1:0]                  char_code,
	output logic                                         last,
	output logic                                         base_invalid
);

	localparam int LEN_W = $clog2(NUM_WIDTH + 1);
	localparam int IDX_W = $clog2(NUM_WIDTH);
	localparam int CW    = sibd_pkg::COUNT_W;

	// configuration
	logic [CW-1:0]                   digit_count_q;
	logic [sibd_pkg::ALPHA_W-1:0]    alpha_low_q;
	logic [sibd_pkg::ALPHA_W-1:0]    alpha_high_q;

	// conversion state
	logic [NUM_WIDTH-1:0]            mag_q;
	logic                            neg_q;
	logic [sibd_pkg::SYM_IDX_W-1:0]  dig_q [NUM_WIDTH];
	logic [LEN_W-1:0]                len_q;
	logic [LEN_W-1:0]                idx_q;

	// output register
	logic                            out_valid_q;
	logic [sibd_pkg::CHAR_W-1:0]     char_q;
	logic                            last_q;
	logic                            invalid_q;

	logic [sibd_pkg::CHAR_W-1:0]     sym [sibd_pkg::SYMBOLS];
	logic [2*sibd_pkg::ALPHA_W-1:0]  alpha;
	logic                            alpha_ok;

	logic [NUM_WIDTH-1:0]            raw;
	logic [NUM_WIDTH-1:0]            mag_in;

	logic [NUM_WIDTH-1:0]            gen_v;
	logic [NUM_WIDTH-1:0]            prop_v;
	logic [NUM_WIDTH:0]              sum_v;
	logic [NUM_WIDTH:0]              carry;
	logic [sibd_pkg::SYM_IDX_W-1:0]  dig_next [NUM_WIDTH];
	logic [CW-1:0]                   dbl;
	logic [CW-1:0]                   tval;
	logic [CW-1:0]                   dval;

	logic [LEN_W-1:0]                rd_idx;
	logic                            out_free;

	assign alpha = {alpha_high_q, alpha_low_q};

	always_comb begin
		for (int i = 0; i < sibd_pkg::SYMBOLS; i++) begin
			sym[i] = alpha[i*sibd_pkg::CHAR_W +: sibd_pkg::CHAR_W];
		end
	end

	// alphabet check: base in range, no sign or NUL symbol, all active symbols distinct
	always_comb begin
		alpha_ok = (digit_count_q >= CW'(sibd_pkg::MIN_BASE)) &&
			(digit_count_q <= CW'(sibd_pkg::MAX_BASE));
		for (int i = 0; i < sibd_pkg::SYMBOLS; i++) begin
			if (CW'(i) < digit_count_q) begin
				if (sym[i] == sibd_pkg::CH_PLUS || sym[i] == sibd_pkg::CH_MINUS ||
					sym[i] == sibd_pkg::CH_NUL) begin
					alpha_ok = 1'b0;
				end
			end
			for (int j = i + 1; j < sibd_pkg::SYMBOLS; j++) begin
				if (CW'(j) < digit_count_q && sym[i] == sym[j]) begin
					alpha_ok = 1'b0;
				end
			end
		end
	end

	assign raw    = number[NUM_WIDTH-1:0];
	assign mag_in = raw[NUM_WIDTH-1] ? (~raw + NUM_WIDTH'(1)) : raw;

	// One binary bit enters per step: every digit doubles and takes the carry from
	// below. A cell generates a carry when 2d >= base and passes one on when
	// 2d + 1 == base, so the carry chain is the carry of one wide add.
	always_comb begin
		for (int i = 0; i < NUM_WIDTH; i++) begin
			dbl       = {dig_q[i], 1'b0};
			gen_v[i]  = (dbl >= digit_count_q);
			prop_v[i] = ((dbl + CW'(1)) == digit_count_q);
		end
		sum_v = {1'b0, gen_v | prop_v} + {1'b0, gen_v} +
			{{NUM_WIDTH{1'b0}}, mag_q[NUM_WIDTH-1]};
		carry = sum_v ^ {1'b0, prop_v};
		for (int i = 0; i < NUM_WIDTH; i++) begin
			dbl  = {dig_q[i], 1'b0};
			tval = dbl | {{(CW-1){1'b0}}, carry[i]};
			dval = carry[i+1] ? (tval - digit_count_q) : tval;
			dig_next[i] = dval[sibd_pkg::SYM_IDX_W-1:0];
		end
	end

	assign rd_idx   = idx_q - LEN_W'(1);
	assign out_free = !out_valid_q || out_ready;

	assign status.alpha_ok   = alpha_ok;
	assign status.neg        = neg_q;
	assign status.out_free   = out_free;
	assign status.digit_last = (idx_q == LEN_W'(1));

	assign out_valid    = out_valid_q;
	assign char_code    = char_q;
	assign last         = last_q;
	assign base_invalid = invalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_count_q <= '0;
			alpha_low_q   <= '0;
			alpha_high_q  <= '0;
			neg_q         <= 1'b0;
			len_q         <= '0;
			idx_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					sibd_pkg::REG_DIGIT_COUNT:   digit_count_q <= cfg_data[CW-1:0];
					sibd_pkg::REG_ALPHABET_LOW:  alpha_low_q   <= cfg_data;
					sibd_pkg::REG_ALPHABET_HIGH: alpha_high_q  <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.start) begin
				neg_q <= raw[NUM_WIDTH-1];
				len_q <= '0;
			end else if (cmd.step) begin
				len_q <= len_q + {{(LEN_W-1){1'b0}}, carry[len_q]};
			end
			if (cmd.load_idx) begin
				idx_q <= (len_q == '0) ? LEN_W'(1) : len_q;
			end else if (cmd.emit_digit) begin
				idx_q <= rd_idx;
			end
			if (cmd.emit_sign || cmd.emit_digit || cmd.emit_error) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			mag_q <= mag_in;
			for (int i = 0; i < NUM_WIDTH; i++) begin
				dig_q[i] <= '0;
			end
		end else if (cmd.step) begin
			mag_q <= {mag_q[NUM_WIDTH-2:0], 1'b0};
			for (int i = 0; i < NUM_WIDTH; i++) begin
				dig_q[i] <= dig_next[i];
			end
		end
		if (cmd.emit_sign) begin
			char_q    <= sibd_pkg::CH_MINUS;
			last_q    <= 1'b0;
			invalid_q <= 1'b0;
		end else if (cmd.emit_digit) begin
			char_q    <= sym[dig_q[rd_idx[IDX_W-1:0]]];
			last_q    <= (idx_q == LEN_W'(1));
			invalid_q <= 1'b0;
		end else if (cmd.emit_error) begin
			char_q    <= sibd_pkg::CH_NUL;
			last_q    <= 1'b1;
			invalid_q <= 1'b1;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/signed_int_to_base_digits.sv =====
// Signed integer to text in a configurable base (2 to 16).
// Channels: num carries one signed number per transaction (low NUM_WIDTH bits
// used, top one of those is the sign); text carries one character per transaction
// with last marking the final character of a number. Both use valid/ready.
// Configuration: cfg_wr_en/cfg_index/cfg_data write digit_count (0), alphabet_low (1)
// and alphabet_high (2); write only while the block is idle. Other indexes drop.
// Output: '-' first for a negative number, then the digits most significant first.
// A bad alphabet (base under 2 or over 16, a '+', '-' or NUL symbol, or a repeated
// symbol) yields one transaction with char_code 0, last 1 and base_invalid 1.
// Sequence: accept, then the conversion steps (one input bit shifted into the
// digit register per cycle), a setup step, then one character per cycle while
// the receiver is ready. A bad alphabet goes from accept straight to the error
// character. The conversion loop keeps the block busy; the next number is taken
// once the last character sits in the output register.
// When the receiver stalls, the output register holds its character and the
// controller waits; no character is lost. Reset clears configuration to zero and
// returns the controller to idle with the output register empty.
`default_nettype none
module signed_int_to_base_digits #(
	parameter int NUM_WIDTH = sibd_pkg::NUM_WIDTH_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	sibd_in_if.sink                                   num,
	sibd_out_if.source                                text,
	input  wire logic                                 cfg_wr_en,
	input  wire logic [sibd_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [sibd_pkg::CFG_DATA_W-1:0]      cfg_data
);

	sibd_pkg::dp_cmd_t    cmd;
	sibd_pkg::dp_status_t status;
	logic                 in_ready;

	// handshake control: idle, conversion, setup, sign/digit/error emission
	sibd_ctrl #(
		.NUM_WIDTH (NUM_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (num.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	assign num.ready = in_ready;

	// configuration, alphabet check, digit register and output register
	sibd_dp #(
		.NUM_WIDTH (NUM_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.number       (num.number),
		.cmd          (cmd),
		.status       (status),
		.out_ready    (text.ready),
		.out_valid    (text.valid),
		.char_code    (text.char_code),
		.last         (text.last),
		.base_invalid (text.base_invalid)
	);

endmodule
`default_nettype wire

// ===== sim/signed_int_to_base_digits_tb.sv =====
`timescale 1ns / 1ps
module signed_int_to_base_digits_tb;
	import sibd_pkg::*;

	localparam int          HALF_PERIOD     = 6;
	localparam int          RESET_CYCLES    = 11;
	localparam int          RANDOM_PHASES   = 10;
	localparam int          ITEMS_PER_PHASE = 9;
	localparam int          QUIET_PHASES    = 2;
	localparam int          LONG_HOLD       = 200;
	localparam int          TAIL_CYCLES     = 80;
	localparam int          TIMEOUT_NS      = 5_000_000;
	localparam int          DIRECTED_ROWS   = 25;
	localparam int          ALPHA_SETTINGS  = 11;
	localparam int          COUNT_MAX       = (1 << COUNT_W) - 1;
	// Index 3 has no register behind it; writes to it must be dropped.
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic [CHAR_W-1:0] char_code;
		logic              last;
		logic              base_invalid;
	} text_item_t;

	// How a directed row is checked: a typed-in error, typed-in text, or the predictor.
	typedef enum {ROW_ERROR, ROW_TEXT, ROW_PREDICT} row_kind_t;

	typedef struct {
		logic [COUNT_W-1:0] count;
		string              symbols;
	} alpha_setting_t;

	typedef struct {
		int unsigned          setting;
		row_kind_t            kind;
		logic [NUMBER_W-1:0]  number;
		string                text;
	} directed_row_t;

	// Setting 0 is the state after reset and is never written.
	alpha_setting_t alpha_table [ALPHA_SETTINGS] = '{
		'{5'd0,  ""},                    // reset: no symbols at all
		'{5'd10, "0123456789"},          // decimal
		'{5'd2,  "01"},                  // binary, smallest base
		'{5'd16, "0123456789ABCDEF"},    // hex, largest base
		'{5'd17, "0123456789ABCDEF"},    // base one over the limit
		'{5'd1,  "0"},                   // base one under the limit
		'{5'd3,  "01+"},                 // active plus sign
		'{5'd3,  "0-1"},                 // active minus sign
		'{5'd4,  "012"},                 // active NUL in the fourth slot
		'{5'd4,  "0120"},                // repeated symbol
		'{5'd3,  "xyz+-zz"}              // junk only beyond the active symbols
	};

	directed_row_t directed_rows [DIRECTED_ROWS] = '{
		'{0,  ROW_ERROR,   32'h0000_0000, ""},
		'{0,  ROW_ERROR,   32'h8000_0000, ""},
		'{1,  ROW_TEXT,    32'h0000_0000, "0"},
		'{1,  ROW_TEXT,    32'h7FFF_FFFF, "2147483647"},
		'{1,  ROW_TEXT,    32'h8000_0000, "-2147483648"},
		'{1,  ROW_TEXT,    32'hFFFF_FFFF, "-1"},
		'{1,  ROW_PREDICT, 32'd12345,     ""},
		'{1,  ROW_PREDICT, 32'hFFF0_EDFA, ""},
		'{2,  ROW_TEXT,    32'h0000_0000, "0"},
		'{2,  ROW_TEXT,    32'h0000_0001, "1"},
		'{2,  ROW_TEXT,    32'hFFFF_FFFF, "-1"},
		'{2,  ROW_PREDICT, 32'h8000_0000, ""},
		'{2,  ROW_PREDICT, 32'h7FFF_FFFF, ""},
		'{2,  ROW_PREDICT, 32'hAAAA_AAAA, ""},
		'{3,  ROW_TEXT,    32'h7FFF_FFFF, "7FFFFFFF"},
		'{3,  ROW_TEXT,    32'h8000_0000, "-80000000"},
		'{3,  ROW_PREDICT, 32'h5555_5555, ""},
		'{4,  ROW_ERROR,   32'h0000_0001, ""},
		'{5,  ROW_ERROR,   32'h0000_0001, ""},
		'{6,  ROW_ERROR,   32'h0000_002A, ""},
		'{7,  ROW_ERROR,   32'hFFFF_FF00, ""},
		'{8,  ROW_ERROR,   32'h0000_0003, ""},
		'{9,  ROW_ERROR,   32'hFFFF_FFFB, ""},
		'{10, ROW_PREDICT, 32'hFFFF_FF9C, ""},
		'{10, ROW_PREDICT, 32'h0000_0064, ""}
	};

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic                   cfg_wr_en;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	sibd_in_if  num_ch ();
	sibd_out_if text_ch ();

	signed_int_to_base_digits dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.num       (num_ch),
		.text      (text_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow copy of the configuration, kept in step with every write.
	logic [COUNT_W-1:0] cfg_count   = '0;
	logic [ALPHA_W-1:0] cfg_alpha_lo = '0;
	logic [ALPHA_W-1:0] cfg_alpha_hi = '0;

	// Characters still owed by the block, oldest first.
	text_item_t  text_expected [$];
	int unsigned mismatch_count  = 0;
	bit          idling_on       = 1'b1;
	bit          long_hold_armed = 1'b0;

	always #HALF_PERIOD clk = ~clk;

	function automatic logic [CHAR_W-1:0] symbol_of(input int unsigned pos);
		logic [2*ALPHA_W-1:0] all = {cfg_alpha_hi, cfg_alpha_lo};
		return all[CHAR_W*pos +: CHAR_W];
	endfunction

	// The alphabet is rechecked for every number, so a bad one is never sticky.
	function automatic bit alphabet_valid();
		logic [CHAR_W-1:0] sym;
		if (cfg_count < MIN_BASE || cfg_count > MAX_BASE) begin
			return 1'b0;
		end
		for (int i = 0; i < cfg_count; i++) begin
			sym = symbol_of(i);
			if (sym == CH_PLUS || sym == CH_MINUS || sym == CH_NUL) begin
				return 1'b0;
			end
			for (int j = i + 1; j < cfg_count; j++) begin
				if (symbol_of(j) == sym) begin
					return 1'b0;
				end
			end
		end
		return 1'b1;
	endfunction

	// Queue the characters one number turns into under the current alphabet.
	function automatic void render_number(input logic [NUMBER_W-1:0] value);
		logic [NUMBER_W-1:0]  mag;
		logic [SYM_IDX_W-1:0] digits [NUMBER_W];
		int unsigned          n;
		text_item_t           item;
		if (!alphabet_valid()) begin
			item.char_code    = CH_NUL;
			item.last         = 1'b1;
			item.base_invalid = 1'b1;
			text_expected.push_back(item);
			return;
		end
		// Two's complement negate; the most negative value stays 2^31 as unsigned.
		mag = value[NUMBER_W-1] ? (~value + 1'b1) : value;
		n = 0;
		do begin
			digits[n] = SYM_IDX_W'(mag % cfg_count);
			mag       = mag / cfg_count;
			n++;
		end while (mag != 0 && n < NUMBER_W);
		item.base_invalid = 1'b0;
		if (value[NUMBER_W-1]) begin
			item.char_code = CH_MINUS;
			item.last      = 1'b0;
			text_expected.push_back(item);
		end
		for (int k = n; k > 0; k--) begin
			item.char_code = symbol_of(digits[k-1]);
			item.last      = (k == 1);
			text_expected.push_back(item);
		end
	endfunction

	// One register write per cycle; the caller drops the enable when done.
	task automatic cfg_write(input logic [CFG_INDEX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		case (index)
			REG_DIGIT_COUNT:   cfg_count    = data[COUNT_W-1:0];
			REG_ALPHABET_LOW:  cfg_alpha_lo = data;
			REG_ALPHABET_HIGH: cfg_alpha_hi = data;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Write all three registers, then poke the unused index with junk.
	task automatic load_alphabet(input logic [COUNT_W-1:0] count,
			input logic [2*ALPHA_W-1:0] alpha);
		cfg_write(REG_DIGIT_COUNT, CFG_DATA_W'(count));
		cfg_write(REG_ALPHABET_LOW, alpha[ALPHA_W-1:0]);
		cfg_write(REG_ALPHABET_HIGH, alpha[2*ALPHA_W-1:ALPHA_W]);
		cfg_write(REG_UNUSED, {$urandom, $urandom});
		cfg_wr_en <= 1'b0;
	endtask

	// Offer one number and hold it until the transaction completes.
	task automatic send_number(input logic [NUMBER_W-1:0] value, input bit predict);
		int unsigned gap;
		if (idling_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 3);
			num_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		num_ch.valid  <= 1'b1;
		num_ch.number <= value;
		do @(posedge clk); while (!num_ch.ready);
		if (predict) begin
			render_number(value);
		end
	endtask

	// Stop offering and wait until every owed character has arrived.
	task automatic drain_text();
		num_ch.valid <= 1'b0;
		while (text_expected.size() != 0) @(posedge clk);
	endtask

	// Receiver: check each character transaction, then decide ready for the
	// next cycle. A long hold is counted here so the sender keeps pushing.
	initial begin : text_receiver
		int unsigned hold;
		text_item_t  want;
		hold = 0;
		text_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (text_ch.valid && text_ch.ready) begin
				if (text_expected.size() == 0) begin
					$error("char_code: expected none, actual %h", text_ch.char_code);
					mismatch_count++;
				end else begin
					want = text_expected.pop_front();
					if (text_ch.char_code !== want.char_code) begin
						$error("char_code: expected %h, actual %h",
							want.char_code, text_ch.char_code);
						mismatch_count++;
					end
					if (text_ch.last !== want.last) begin
						$error("last: expected %b, actual %b", want.last, text_ch.last);
						mismatch_count++;
					end
					if (text_ch.base_invalid !== want.base_invalid) begin
						$error("base_invalid: expected %b, actual %b",
							want.base_invalid, text_ch.base_invalid);
						mismatch_count++;
					end
				end
			end
			if (hold != 0) begin
				hold--;
				text_ch.ready <= 1'b0;
			end else if (long_hold_armed) begin
				long_hold_armed = 1'b0;
				hold = LONG_HOLD - 1;
				text_ch.ready <= 1'b0;
			end else if (idling_on && text_ch.ready && $urandom_range(0, 4) == 0) begin
				// Random burst with ready low.
				hold = $urandom_range(0, 2);
				text_ch.ready <= 1'b0;
			end else begin
				text_ch.ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		int unsigned          active_setting;
		directed_row_t        row;
		text_item_t           item;
		logic [COUNT_W-1:0]   count;
		logic [2*ALPHA_W-1:0] alpha;
		logic [CHAR_W-1:0]    sym;
		logic [NUMBER_W-1:0]  value;
		bit                   fresh;
		int unsigned          pick;
		int unsigned          other;

		num_ch.valid  <= 1'b0;
		num_ch.number <= '0;
		cfg_wr_en     <= 1'b0;
		cfg_index     <= '0;
		cfg_data      <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: walk the table, reloading the alphabet between groups.
		active_setting = 0;
		for (int r = 0; r < DIRECTED_ROWS; r++) begin
			row = directed_rows[r];
			if (row.setting != active_setting) begin
				drain_text();
				active_setting = row.setting;
				alpha = '0;
				for (int i = 0; i < alpha_table[active_setting].symbols.len() && i < SYMBOLS;
						i++) begin
					alpha[CHAR_W*i +: CHAR_W] = alpha_table[active_setting].symbols[i];
				end
				load_alphabet(alpha_table[active_setting].count, alpha);
			end
			case (row.kind)
				ROW_ERROR: begin
					item.char_code    = CH_NUL;
					item.last         = 1'b1;
					item.base_invalid = 1'b1;
					text_expected.push_back(item);
				end
				ROW_TEXT: begin
					for (int i = 0; i < row.text.len(); i++) begin
						item.char_code    = row.text[i];
						item.last         = (i == row.text.len() - 1);
						item.base_invalid = 1'b0;
						text_expected.push_back(item);
					end
				end
				default: ;
			endcase
			send_number(row.number, row.kind == ROW_PREDICT);
		end

		// Random part: each phase picks an alphabet, good about half the time, otherwise
		// broken in one way, then throws a mix of numbers at it.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			drain_text();
			idling_on = (phase < RANDOM_PHASES - QUIET_PHASES);

			// Junk everywhere first, so inactive slots hold anything at all.
			alpha = {$urandom, $urandom, $urandom, $urandom};
			count = COUNT_W'($urandom_range(MIN_BASE, MAX_BASE));
			for (int i = 0; i < count; i++) begin
				do begin
					sym   = CHAR_W'($urandom_range(1, 255));
					fresh = (sym != CH_PLUS) && (sym != CH_MINUS);
					for (int j = 0; j < i; j++) begin
						if (alpha[CHAR_W*j +: CHAR_W] == sym) begin
							fresh = 1'b0;
						end
					end
				end while (!fresh);
				alpha[CHAR_W*i +: CHAR_W] = sym;
			end
			pick = $urandom_range(0, count - 1);
			case ($urandom_range(0, 11))
				0: count = COUNT_W'($urandom_range(0, MIN_BASE - 1));
				1: count = COUNT_W'($urandom_range(MAX_BASE + 1, COUNT_MAX));
				2: alpha[CHAR_W*pick +: CHAR_W] = CH_PLUS;
				3: alpha[CHAR_W*pick +: CHAR_W] = CH_MINUS;
				4: alpha[CHAR_W*pick +: CHAR_W] = CH_NUL;
				5: begin
					other = (pick + $urandom_range(1, count - 1)) % count;
					alpha[CHAR_W*pick +: CHAR_W] = alpha[CHAR_W*other +: CHAR_W];
				end
				default: ;
			endcase
			load_alphabet(count, alpha);

			// Stall the receiver for a long stretch while numbers keep coming.
			if (phase == 1) begin
				long_hold_armed = 1'b1;
			end

			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				case ($urandom_range(0, 5))
					0: value = $urandom_range(0, 300);
					1: value = -$urandom_range(1, 300);
					2: begin
						case ($urandom_range(0, 4))
							0: value = 32'h8000_0000;
							1: value = 32'h7FFF_FFFF;
							2: value = 32'h0000_0000;
							3: value = 32'hFFFF_FFFF;
							default: value = 32'h0000_0001;
						endcase
					end
					default: value = $urandom;
				endcase
				send_number(value, 1'b1);
			end
		end

		drain_text();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("status: fail");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/sibd_pkg.sv
rtl/core/sibd_in_if.sv
rtl/core/sibd_out_if.sv
rtl/core/sibd_ctrl.sv
rtl/core/sibd_dp.sv
rtl/core/signed_int_to_base_digits.sv
sim/signed_int_to_base_digits_tb.sv
